>>> src/srs_pkg.sv
`default_nettype none

package srs_pkg;

  localparam int PL_BYTES   = 20;
  localparam int PL_W       = 8 * PL_BYTES;
  localparam int SEQ_W      = 4;
  localparam int CNT_W      = 4;
  localparam int CSUM_W     = 32;
  localparam int ACKF_W     = 16;
  localparam int BIDX_W     = 5;
  localparam int WL_W       = 4;
  localparam int MOD_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_W      = 5;
  localparam int RED_W      = 6;
  localparam int IN_DATA_W  = 224;
  localparam int OUT_DATA_W = 208;
  localparam int OUT_PAD_W  = OUT_DATA_W - (SEQ_W + PL_W + CSUM_W + 2 + CNT_W);

  localparam logic [MOD_W-1:0] MOD_MIN = MOD_W'(2);
  localparam logic [MOD_W-1:0] MOD_MAX = MOD_W'(16);
  localparam logic [WL_W-1:0]  WL_RESET  = WL_W'(6);
  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(12);

  typedef enum logic [1:0] {
    MODE_MSG,
    MODE_ACK,
    MODE_TMO,
    MODE_NONE
  } mode_t;

  typedef enum logic [2:0] {
    EV_SENT,
    EV_FULL,
    EV_ACKED,
    EV_DUP,
    EV_CORRUPT,
    EV_RESENT,
    EV_IDLE_TMO
  } event_t;

  typedef enum logic [1:0] {
    TMR_NONE,
    TMR_START,
    TMR_STOP,
    TMR_RESTART
  } timer_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LIMIT,
    REG_SEQ_MODULUS
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEND_WR,
    S_CSUM,
    S_ACK_CHK,
    S_RD_FIRST,
    S_RD_LAST,
    S_ACK_RANGE,
    S_REDUCE,
    S_ACK_MARK,
    S_SLIDE,
    S_RD_OLD,
    S_RS_CAP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic              start;
    logic [CSUM_W-1:0] init;
  } csum_ctl_t;

  typedef struct packed {
    logic busy;
  } csum_sts_t;

endpackage

`default_nettype wire

>>> src/srs_csum.sv
`default_nettype none

module srs_csum
  import srs_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 20
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire csum_ctl_t         ctl,
  input  wire logic [PL_W-1:0]   payload,
  output csum_sts_t              sts,
  output logic      [CSUM_W-1:0] sum
);

  logic [BIDX_W-1:0] cnt;
  logic              busy;
  logic [7:0]        pbyte [PL_BYTES];
  logic [7:0]        cur;

  for (genvar i = 0; i < PL_BYTES; i++) begin : g_bytes
    assign pbyte[i] = payload[8*i +: 8];
  end

  assign cur      = pbyte[cnt];
  assign sts.busy = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctl.start) begin
      busy <= 1'b1;
    end else if (busy && cnt == BIDX_W'(PAYLOAD_BYTES - 1)) begin
      busy <= 1'b0;
    end
  end

  // one signed byte per cycle
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      sum <= ctl.init;
      cnt <= '0;
    end else if (busy) begin
      sum <= sum + {{(CSUM_W-8){cur[7]}}, cur};
      cnt <= cnt + BIDX_W'(1);
    end
  end

endmodule

`default_nettype wire

>>> src/selective_repeat_sender.sv
`default_nettype none

// Selective-repeat ARQ sender. One word in, one word out (mode 3 is dropped
// with no result). The checksum is built by one shared adder, one payload byte
// per cycle. A send writes the packet buffer and a resend reads it; either then
// runs the checksum and loads the result register. An ack runs the checksum,
// is checked for corruption and by the first range check, and is then checked
// against the window; an accepted ack marks its slot and slides the window one
// slot at a time. The next sequence number and the ack offset are reduced
// modulo the sequence modulus one step at a time. A full window or a timeout
// with nothing in flight goes straight to the result register. Packets are
// kept in a MAX_WINDOW-deep buffer with one registered read port. The input
// is not ready while a word is in work. The finished word waits in an output
// register, and a word whose result register is still occupied stalls until
// it frees.
module selective_repeat_sender
  import srs_pkg::*;
#(
  parameter int MAX_WINDOW    = 8,
  parameter int PAYLOAD_BYTES = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // data_word_low, data_word_mid, data_word_high, ack_packet_seq, ack_number,
  // ack_checksum
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // mode
  input  wire logic [1:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // out_seq, out_word_low, out_word_mid, out_word_high, out_checksum,
  // timer_action, packets_in_flight, zero pad
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // event_kind
  output logic [2:0]                 m_axis_tuser,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WSUM_W = (SLOT_W + 2 > CNT_W + 1) ? SLOT_W + 2 : CNT_W + 1;
  localparam int MEM_W  = SEQ_W + PL_W;

  function automatic logic [SLOT_W-1:0] wrap(input logic [WSUM_W-1:0] x);
    logic [WSUM_W-1:0] y;
    y = (x >= WSUM_W'(MAX_WINDOW)) ? x - WSUM_W'(MAX_WINDOW) : x;
    return y[SLOT_W-1:0];
  endfunction

  state_t state, state_next;

  logic [WL_W-1:0]  window_limit;
  logic [MOD_W-1:0] seq_modulus;
  logic [MOD_W-1:0] eff_mod;

  logic [CNT_W-1:0]      count;
  logic [SLOT_W-1:0]     oldest;
  logic [SEQ_W-1:0]      next_seq;
  logic [MAX_WINDOW-1:0] acked;

  mode_t              mode_q;
  logic [PL_W-1:0]    pl;
  logic [PL_W-1:0]    pl_in;
  logic [ACKF_W-1:0]  anum;
  logic [CSUM_W-1:0]  acks;
  logic [ACKF_W-1:0]  aseq_in, anum_in;

  logic [MEM_W-1:0]  mem [MAX_WINDOW];
  logic [MEM_W-1:0]  rd_q;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] wr_addr;
  logic [SEQ_W-1:0]  rd_seq;

  logic [SEQ_W-1:0]        first;
  logic                    in_win;
  logic signed [RED_W-1:0] red;
  logic                    moved;

  event_t           res_kind;
  timer_t           res_timer;
  logic [SEQ_W-1:0] res_seq;
  logic             res_pkt;

  csum_ctl_t         csum_ctl;
  csum_sts_t         csum_sts;
  logic [CSUM_W-1:0] csum_sum;

  logic accept, out_free, window_ok, red_done, ack_bad, ack_dup, mark_ok, slide_go;
  logic [SLOT_W-1:0] mark_addr;
  logic [SLOT_W-1:0] last_addr;

  // payload bytes beyond PAYLOAD_BYTES are dropped
  for (genvar i = 0; i < PL_BYTES; i++) begin : g_trim
    if (i < PAYLOAD_BYTES) begin : g_keep
      assign pl_in[8*i +: 8] = s_axis_tdata[8*i +: 8];
    end else begin : g_zero
      assign pl_in[8*i +: 8] = 8'h00;
    end
  end

  assign aseq_in = s_axis_tdata[PL_W +: ACKF_W];
  assign anum_in = s_axis_tdata[PL_W + ACKF_W +: ACKF_W];

  always_comb begin
    if (seq_modulus < MOD_MIN) begin
      eff_mod = MOD_MIN;
    end else if (seq_modulus > MOD_MAX) begin
      eff_mod = MOD_MAX;
    end else begin
      eff_mod = seq_modulus;
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign window_ok = (count < window_limit) &&
                     (WSUM_W'(count) < WSUM_W'(MAX_WINDOW));
  assign red_done  = !red[RED_W-1] && (red < $signed({1'b0, eff_mod}));
  assign ack_bad   = csum_sum != acks;
  assign ack_dup   = (count == '0) || anum[ACKF_W-1] ||
                     (anum[ACKF_W-2:0] >= (ACKF_W-1)'(eff_mod));
  assign mark_ok   = in_win && (red[CNT_W-1:0] < count);
  assign slide_go  = (count != '0) && acked[oldest];
  assign rd_seq    = rd_q[PL_W +: SEQ_W];
  assign wr_addr   = wrap(WSUM_W'(oldest) + WSUM_W'(count));
  assign last_addr = wrap(WSUM_W'(oldest) + WSUM_W'(count) - WSUM_W'(1));
  assign mark_addr = wrap(WSUM_W'(oldest) + WSUM_W'(red[CNT_W-1:0]));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_t'(s_axis_tuser))
            MODE_MSG:  state_next = window_ok ? S_SEND_WR : S_FINISH;
            MODE_ACK:  state_next = S_CSUM;
            MODE_TMO:  state_next = (count == '0) ? S_FINISH : S_RD_OLD;
            MODE_NONE: state_next = S_IDLE;
          endcase
        end
      end
      S_SEND_WR: state_next = S_CSUM;
      S_CSUM: begin
        if (!csum_sts.busy) begin
          priority case (mode_q)
            MODE_MSG: state_next = S_REDUCE;
            MODE_ACK: state_next = S_ACK_CHK;
            default:  state_next = S_FINISH;
          endcase
        end
      end
      S_ACK_CHK:   state_next = (ack_bad || ack_dup) ? S_FINISH : S_RD_FIRST;
      S_RD_FIRST:  state_next = S_RD_LAST;
      S_RD_LAST:   state_next = S_ACK_RANGE;
      S_ACK_RANGE: state_next = S_REDUCE;
      S_REDUCE: begin
        if (red_done) begin
          state_next = (mode_q == MODE_MSG) ? S_FINISH : S_ACK_MARK;
        end
      end
      S_ACK_MARK: state_next = mark_ok ? S_SLIDE : S_FINISH;
      S_SLIDE:    state_next = slide_go ? S_SLIDE : S_FINISH;
      S_RD_OLD:   state_next = S_RS_CAP;
      S_RS_CAP:   state_next = S_CSUM;
      S_FINISH:   state_next = out_free ? S_IDLE : S_FINISH;
      default:    state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = oldest;
    csum_ctl      = '{start: 1'b0, init: '0};
    unique case (state)
      S_IDLE: begin
        if (accept && mode_t'(s_axis_tuser) == MODE_ACK) begin
          csum_ctl.start = 1'b1;
          csum_ctl.init  = {{(CSUM_W-ACKF_W){aseq_in[ACKF_W-1]}}, aseq_in} +
                           {{(CSUM_W-ACKF_W){anum_in[ACKF_W-1]}}, anum_in};
        end
      end
      S_SEND_WR: begin
        csum_ctl.start = 1'b1;
        csum_ctl.init  = CSUM_W'(next_seq) - CSUM_W'(1);
      end
      S_RS_CAP: begin
        csum_ctl.start = 1'b1;
        csum_ctl.init  = CSUM_W'(rd_seq) - CSUM_W'(1);
      end
      S_RD_FIRST, S_RD_OLD: begin
        rd_en = 1'b1;
      end
      S_RD_LAST: begin
        rd_en   = 1'b1;
        rd_addr = last_addr;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  srs_csum #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_csum (
    .clk     (clk),
    .rst     (rst),
    .ctl     (csum_ctl),
    .payload (pl),
    .sts     (csum_sts),
    .sum     (csum_sum)
  );

  // packet buffer
  always_ff @(posedge clk) begin
    if (state == S_SEND_WR) begin
      mem[wr_addr] <= {next_seq, pl};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      oldest        <= '0;
      next_seq      <= '0;
      acked         <= '0;
      window_limit  <= WL_RESET;
      seq_modulus   <= MOD_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_WINDOW_LIMIT: window_limit <= cfg_data[WL_W-1:0];
          REG_SEQ_MODULUS:  seq_modulus  <= cfg_data[MOD_W-1:0];
        endcase
      end
      if (state == S_FINISH && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_SEND_WR: begin
          acked[wr_addr] <= 1'b0;
          count          <= count + CNT_W'(1);
        end
        S_REDUCE: begin
          if (red_done && mode_q == MODE_MSG) begin
            next_seq <= red[SEQ_W-1:0];
          end
        end
        S_ACK_MARK: begin
          if (mark_ok) begin
            acked[mark_addr] <= 1'b1;
          end
        end
        S_SLIDE: begin
          if (slide_go) begin
            acked[oldest] <= 1'b0;
            oldest        <= wrap(WSUM_W'(oldest) + WSUM_W'(1));
            count         <= count - CNT_W'(1);
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          mode_q    <= mode_t'(s_axis_tuser);
          pl        <= pl_in;
          anum      <= anum_in;
          acks      <= s_axis_tdata[PL_W + 2*ACKF_W +: CSUM_W];
          res_pkt   <= 1'b0;
          res_timer <= TMR_NONE;
          res_kind  <= (mode_t'(s_axis_tuser) == MODE_MSG) ? EV_FULL : EV_IDLE_TMO;
        end
      end
      S_SEND_WR: begin
        res_kind  <= EV_SENT;
        res_pkt   <= 1'b1;
        res_seq   <= next_seq;
        res_timer <= (count == '0) ? TMR_START : TMR_NONE;
        red       <= RED_W'(next_seq) + RED_W'(1);
      end
      S_ACK_CHK: begin
        res_kind <= ack_bad ? EV_CORRUPT : EV_DUP;
      end
      S_RD_LAST: begin
        first <= rd_seq;
      end
      S_ACK_RANGE: begin
        in_win <= (first <= rd_seq) ?
                  (anum[SEQ_W-1:0] >= first && anum[SEQ_W-1:0] <= rd_seq) :
                  (anum[SEQ_W-1:0] >= first || anum[SEQ_W-1:0] <= rd_seq);
        red    <= RED_W'(anum[SEQ_W-1:0]) - RED_W'(first);
      end
      S_REDUCE: begin
        if (!red_done) begin
          red <= red[RED_W-1] ? red + RED_W'(eff_mod) : red - RED_W'(eff_mod);
        end
      end
      S_ACK_MARK: begin
        moved    <= 1'b0;
        res_kind <= EV_DUP;
      end
      S_SLIDE: begin
        if (slide_go) begin
          moved <= 1'b1;
        end else begin
          res_kind  <= EV_ACKED;
          res_timer <= !moved ? TMR_NONE : ((count != '0) ? TMR_RESTART : TMR_STOP);
        end
      end
      S_RS_CAP: begin
        pl        <= rd_q[PL_W-1:0];
        res_seq   <= rd_seq;
        res_kind  <= EV_RESENT;
        res_pkt   <= 1'b1;
        res_timer <= TMR_START;
      end
      S_FINISH: begin
        if (out_free) begin
          m_axis_tuser <= res_kind;
          m_axis_tdata <= {{OUT_PAD_W{1'b0}}, count, res_timer,
                           res_pkt ? csum_sum : {CSUM_W{1'b0}},
                           res_pkt ? pl : {PL_W{1'b0}},
                           res_pkt ? res_seq : {SEQ_W{1'b0}}};
        end
      end
      default: begin
        res_pkt <= res_pkt;
      end
    endcase
  end

endmodule

`default_nettype wire
